FILE: design/sct_pkg.sv
// shared types, constants and elaboration-time table functions for the rotation block
package sct_pkg;

    localparam int QF = 30;
    localparam int WORD_W = 32;
    localparam int WIDE_W = 34;

    typedef logic signed [WORD_W-1:0] t_q30;
    typedef logic signed [WIDE_W-1:0] t_wide;

    typedef enum logic [1:0] {
        REG_ORIGIN_LON = 2'd0,
        REG_ORIGIN_LAT = 2'd1,
        REG_POLE_LON   = 2'd2,
        REG_POLE_LAT   = 2'd3
    } t_reg_idx;

    localparam t_q30 KINV_Q = 32'sd652032874;
    localparam t_q30 Q_ONE  = 32'sd1073741824;

    // shift-subtract quotient, elaboration only
    function automatic longint unsigned long_div(input longint unsigned num,
                                                 input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint atan_recip(input longint unsigned n);
        longint unsigned p;
        longint unsigned t;
        longint sum;
        p = long_div(64'd1 << 60, n);
        sum = 0;
        for (int k = 0; k < 64; k++) begin
            if (p == 0) break;
            t = long_div(p, 64'(2 * k + 1));
            if (k % 2 == 1) sum = sum - longint'(t);
            else sum = sum + longint'(t);
            p = long_div(p, n * n);
        end
        return sum;
    endfunction

    function automatic longint atan_pow2(input int i);
        longint sum;
        longint unsigned t;
        int e;
        sum = 0;
        if (i >= 60) return 0;
        for (int k = 0; k < 64; k++) begin
            e = i * (2 * k + 1);
            if (e > 60) break;
            t = long_div(64'd1 << (60 - e), 64'(2 * k + 1));
            if (k % 2 == 1) sum = sum - longint'(t);
            else sum = sum + longint'(t);
        end
        return sum;
    endfunction

    // atan(2^-i) in binary angle units of 2^angle_bits per turn, rounded
    function automatic longint atan_entry(input int angle_bits, input int i);
        longint unsigned d;
        longint unsigned rem;
        longint unsigned q;
        if (i == 0) return longint'(64'd1 << (angle_bits - 3));
        d = longint'(4 * atan_recip(5) - atan_recip(239)) * 64'd8;
        rem = longint'(atan_pow2(i));
        q = '0;
        for (int b = 0; b <= angle_bits; b++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= d) begin
                rem = rem - d;
                q[0] = 1'b1;
            end
        end
        return longint'((q + 64'd1) >> 1);
    endfunction

    // q30 product, round half up
    function automatic logic signed [35:0] qmul(input t_wide a, input t_wide b);
        logic signed [67:0] p;
        p = a * b + (68'sd1 <<< (QF - 1));
        return 36'(p >>> QF);
    endfunction

    function automatic t_q30 clamp_q(input logic signed [63:0] v);
        if (v > 64'(Q_ONE)) return Q_ONE;
        if (v < -64'(Q_ONE)) return -Q_ONE;
        return 32'(v);
    endfunction

endpackage

FILE: design/sct_ifs.sv
// valid/ready channel interfaces for point words and result words
interface sct_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] lon_in;
    logic signed [31:0] lat_in;
    modport source (output valid, lon_in, lat_in, input ready);
    modport sink (input valid, lon_in, lat_in, output ready);
endinterface

interface sct_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] lon_out;
    logic signed [31:0] lat_out;
    logic               degenerate;
    modport source (output valid, lon_out, lat_out, degenerate, input ready);
    modport sink (input valid, lon_out, lat_out, degenerate, output ready);
endinterface

FILE: design/sct_delay.sv
// enabled delay line used to keep side data aligned with the pipeline
module sct_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_line [0:D-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < D; k++) r_line[k] <= '0;
        end else if (i_en) begin
            r_line[0] <= i_d;
            for (int k = 1; k < D; k++) r_line[k] <= r_line[k-1];
        end
    end

    assign o_q = r_line[D-1];

endmodule

FILE: design/sct_sincos.sv
// pipelined rotation cordic giving q30 sine and cosine of a binary angle
module sct_sincos #(
    parameter int ANGLE_BITS    = 32,
    parameter int CORDIC_STAGES = 30
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [ANGLE_BITS-1:0] i_th,
    output sct_pkg::t_q30                o_s,
    output sct_pkg::t_q30                o_c
);

    localparam int A  = ANGLE_BITS;
    localparam int N  = CORDIC_STAGES;
    localparam int ZW = A + 1;
    localparam int XW = 34;
    localparam logic signed [A-1:0] QUARTER = A'(64'd1 << (A - 2));

    logic signed [XW-1:0] w_x [0:N];
    logic signed [XW-1:0] w_y [0:N];
    logic signed [ZW-1:0] w_z [0:N];
    logic                 w_neg [0:N];

    logic signed [ZW-1:0] r_z0;
    logic                 r_neg0;
    logic signed [A-1:0]  n_fold;
    logic                 n_neg;

    // folding by a half turn is a flip of the top bit
    always_comb begin
        n_neg  = (i_th > QUARTER) || (i_th < -QUARTER);
        n_fold = n_neg ? {~i_th[A-1], i_th[A-2:0]} : i_th;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z0   <= ZW'(n_fold);
            r_neg0 <= n_neg;
        end
    end

    assign w_x[0]   = XW'(sct_pkg::KINV_Q);
    assign w_y[0]   = '0;
    assign w_z[0]   = r_z0;
    assign w_neg[0] = r_neg0;

    for (genvar g = 0; g < N; g++) begin : g_stage
        localparam logic signed [ZW-1:0] ATAB = ZW'(sct_pkg::atan_entry(A, g));
        logic signed [XW-1:0] r_x;
        logic signed [XW-1:0] r_y;
        logic signed [ZW-1:0] r_z;
        logic                 r_neg;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        assign dx = w_y[g] >>> g;
        assign dy = w_x[g] >>> g;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_z[g] >= 0) begin
                    r_x <= w_x[g] - dx;
                    r_y <= w_y[g] + dy;
                    r_z <= w_z[g] - ATAB;
                end else begin
                    r_x <= w_x[g] + dx;
                    r_y <= w_y[g] - dy;
                    r_z <= w_z[g] + ATAB;
                end
                r_neg <= w_neg[g];
            end
        end
        assign w_x[g+1]   = r_x;
        assign w_y[g+1]   = r_y;
        assign w_z[g+1]   = r_z;
        assign w_neg[g+1] = r_neg;
    end

    sct_pkg::t_q30 r_s;
    sct_pkg::t_q30 r_c;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c <= sct_pkg::clamp_q(64'(w_neg[N] ? -w_x[N] : w_x[N]));
            r_s <= sct_pkg::clamp_q(64'(w_neg[N] ? -w_y[N] : w_y[N]));
        end
    end

    assign o_s = r_s;
    assign o_c = r_c;

endmodule

FILE: design/sct_atan2.sv
// pipelined vectoring cordic giving the full-quadrant angle of a vector
module sct_atan2 #(
    parameter int ANGLE_BITS    = 32,
    parameter int CORDIC_STAGES = 30
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  sct_pkg::t_wide               i_y,
    input  sct_pkg::t_wide               i_x,
    output logic signed [ANGLE_BITS-1:0] o_z
);

    localparam int A  = ANGLE_BITS;
    localparam int N  = CORDIC_STAGES;
    localparam int ZW = A + 1;
    localparam int XW = 36;
    localparam logic signed [ZW-1:0] ZQ = ZW'(64'd1 << (A - 2));

    logic signed [XW-1:0] w_x [0:N];
    logic signed [XW-1:0] w_y [0:N];
    logic signed [ZW-1:0] w_z [0:N];
    logic                 w_zero [0:N];

    logic signed [XW-1:0] r_x0;
    logic signed [XW-1:0] r_y0;
    logic signed [ZW-1:0] r_z0;
    logic                 r_zero0;
    logic signed [XW-1:0] xin;
    logic signed [XW-1:0] yin;

    assign xin = XW'(i_x);
    assign yin = XW'(i_y);

    // left half plane turned by a quarter first
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero0 <= (i_x == 0) && (i_y == 0);
            if (xin < 0) begin
                if (yin >= 0) begin
                    r_x0 <= yin;
                    r_y0 <= -xin;
                    r_z0 <= ZQ;
                end else begin
                    r_x0 <= -yin;
                    r_y0 <= xin;
                    r_z0 <= -ZQ;
                end
            end else begin
                r_x0 <= xin;
                r_y0 <= yin;
                r_z0 <= '0;
            end
        end
    end

    assign w_x[0]    = r_x0;
    assign w_y[0]    = r_y0;
    assign w_z[0]    = r_z0;
    assign w_zero[0] = r_zero0;

    for (genvar g = 0; g < N; g++) begin : g_stage
        localparam logic signed [ZW-1:0] ATAB = ZW'(sct_pkg::atan_entry(A, g));
        logic signed [XW-1:0] r_x;
        logic signed [XW-1:0] r_y;
        logic signed [ZW-1:0] r_z;
        logic                 r_zero;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        assign dx = w_y[g] >>> g;
        assign dy = w_x[g] >>> g;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_y[g] >= 0) begin
                    r_x <= w_x[g] + dx;
                    r_y <= w_y[g] - dy;
                    r_z <= w_z[g] + ATAB;
                end else begin
                    r_x <= w_x[g] - dx;
                    r_y <= w_y[g] + dy;
                    r_z <= w_z[g] - ATAB;
                end
                r_zero <= w_zero[g];
            end
        end
        assign w_x[g+1]    = r_x;
        assign w_y[g+1]    = r_y;
        assign w_z[g+1]    = r_z;
        assign w_zero[g+1] = r_zero;
    end

    logic signed [A-1:0] r_z;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z <= w_zero[N] ? '0 : w_z[N][A-1:0];
        end
    end

    assign o_z = r_z;

endmodule

FILE: design/sct_isqrt.sv
// pipelined integer square root, one result bit per stage
module sct_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [60:0] i_n,
    output logic [30:0] o_root
);

    localparam int STEPS = 31;
    localparam int W = 62;

    logic [W-1:0] w_n [0:STEPS];
    logic [W-1:0] w_r [0:STEPS];

    assign w_n[0] = W'(i_n);
    assign w_r[0] = '0;

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        localparam logic [W-1:0] BIT = W'(64'd1 << (60 - 2 * g));
        logic [W-1:0] r_n;
        logic [W-1:0] r_r;
        logic [W-1:0] trial;
        assign trial = w_r[g] + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_n[g] >= trial) begin
                    r_n <= w_n[g] - trial;
                    r_r <= (w_r[g] >> 1) + BIT;
                end else begin
                    r_n <= w_n[g];
                    r_r <= w_r[g] >> 1;
                end
            end
        end
        assign w_n[g+1] = r_n;
        assign w_r[g+1] = r_r;
    end

    assign o_root = w_r[STEPS][30:0];

endmodule

FILE: design/spherical_coordinate_rotation.sv
// Spherical frame rotation: maps a point's longitude and latitude (binary angles,
// 2^32 per turn) into a frame set by the configured origin and north pole.
// One point is accepted every cycle while the result side is not stalled; a
// result passes through five parallel sine/cosine CORDIC pipelines, five
// multiply stages, the 31-step square-root pipeline and the two parallel
// arctangent CORDIC pipelines. Registers sit at byte addresses 0, 4, 8, 12:
// origin_lon, origin_lat, pole_lon, pole_lat; write them while no point is in
// flight. degenerate marks a point at the new pole or a pole with zero cosine,
// and then lon_out is 0.
module spherical_coordinate_rotation #(
    parameter int ANGLE_BITS    = 32,
    parameter int CORDIC_STAGES = 30
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sct_in_if.sink      i_in,
    sct_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int A       = ANGLE_BITS;
    localparam int N       = CORDIC_STAGES;
    localparam int LS      = N + 2;
    localparam int LQ      = 31;
    localparam int LA      = N + 2;
    localparam int LON_DLY = LQ - 2;
    localparam int LAT     = 1 + LS + 5 + LQ + LA;
    localparam int UP_IN   = (A >= 32) ? A - 32 : 0;
    localparam int DN_IN   = (A < 32) ? 32 - A : 0;
    localparam int SH_DN   = (A > 32) ? A - 32 : 1;
    localparam int SH_UP   = (A < 32) ? 32 - A : 0;

    function automatic logic signed [A-1:0] to_int(input logic signed [31:0] v);
        logic signed [63:0] t;
        t = 64'(v);
        if (A >= 32) t = t <<< UP_IN;
        else t = t >>> DN_IN;
        return A'(t);
    endfunction

    function automatic logic signed [63:0] to_out32(input logic signed [A-1:0] z);
        logic signed [63:0] t;
        t = 64'(z);
        if (A > 32) t = (t + (64'sd1 <<< (SH_DN - 1))) >>> SH_DN;
        else t = t <<< SH_UP;
        return t;
    endfunction

    // configuration registers
    logic signed [31:0] r_origin_lon;
    logic signed [31:0] r_origin_lat;
    logic signed [31:0] r_pole_lon;
    logic signed [31:0] r_pole_lat;
    sct_pkg::t_reg_idx  w_idx;

    assign w_idx  = sct_pkg::t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_lon <= 32'sd1073741824;
            r_origin_lat <= '0;
            r_pole_lon   <= '0;
            r_pole_lat   <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                sct_pkg::REG_ORIGIN_LON: r_origin_lon <= pwdata;
                sct_pkg::REG_ORIGIN_LAT: r_origin_lat <= pwdata;
                sct_pkg::REG_POLE_LON:   r_pole_lon   <= pwdata;
                sct_pkg::REG_POLE_LAT:   r_pole_lat   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            sct_pkg::REG_ORIGIN_LON: prdata = r_origin_lon;
            sct_pkg::REG_ORIGIN_LAT: prdata = r_origin_lat;
            sct_pkg::REG_POLE_LON:   prdata = r_pole_lon;
            sct_pkg::REG_POLE_LAT:   prdata = r_pole_lat;
            default:                 prdata = '0;
        endcase
    end

    // whole pipeline advances together, output register parts the sides
    logic r_out_valid;
    logic w_en;

    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    // angle setup
    logic signed [A-1:0] r_th_b0;
    logic signed [A-1:0] r_th_bp;
    logic signed [A-1:0] r_th_b1;
    logic signed [A-1:0] r_th_d1;
    logic signed [A-1:0] r_th_d0;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_th_b0 <= to_int(r_origin_lat);
            r_th_bp <= to_int(r_pole_lat);
            r_th_b1 <= to_int(i_in.lat_in);
            r_th_d1 <= to_int(r_pole_lon) - to_int(i_in.lon_in);
            r_th_d0 <= to_int(r_pole_lon) - to_int(r_origin_lon);
        end
    end

    sct_pkg::t_q30 w_sb0, w_cb0, w_sbp, w_cbp, w_sb1, w_cb1, w_sd1, w_cd1, w_sd0;

    sct_sincos #(.ANGLE_BITS(A), .CORDIC_STAGES(N)) u_sc_b0 (
        .i_clk(i_clk), .i_en(w_en), .i_th(r_th_b0), .o_s(w_sb0), .o_c(w_cb0));
    sct_sincos #(.ANGLE_BITS(A), .CORDIC_STAGES(N)) u_sc_bp (
        .i_clk(i_clk), .i_en(w_en), .i_th(r_th_bp), .o_s(w_sbp), .o_c(w_cbp));
    sct_sincos #(.ANGLE_BITS(A), .CORDIC_STAGES(N)) u_sc_b1 (
        .i_clk(i_clk), .i_en(w_en), .i_th(r_th_b1), .o_s(w_sb1), .o_c(w_cb1));
    sct_sincos #(.ANGLE_BITS(A), .CORDIC_STAGES(N)) u_sc_d1 (
        .i_clk(i_clk), .i_en(w_en), .i_th(r_th_d1), .o_s(w_sd1), .o_c(w_cd1));
    sct_sincos #(.ANGLE_BITS(A), .CORDIC_STAGES(N)) u_sc_d0 (
        .i_clk(i_clk), .i_en(w_en), .i_th(r_th_d0), .o_s(w_sd0), .o_c());

    // product stages
    sct_pkg::t_q30 r1_p1, r1_p2, r1_t1, r1_t2, r1_sbp, r1_cbp, r1_sb1, r1_cd1, r1_sb0;
    sct_pkg::t_q30 r2_q, r2_s, r2_bb, r2_p1, r2_sbp, r2_sb1, r2_sb0;
    logic          r2_cbpz;
    sct_pkg::t_q30 r3_sb2, r3_s, r3_bb, r3_sbp, r3_sb1, r3_sb0;
    logic          r3_cbpz;
    logic signed [63:0] r4_sq;
    sct_pkg::t_q30 r4_qs, r4_sb2, r4_s, r4_bb, r4_sb1, r4_sb0;
    logic          r4_cbpz;
    logic [60:0]   r5_n;
    sct_pkg::t_wide r5_c;
    sct_pkg::t_q30 r5_sb2, r5_s, r5_bb, r5_sb0;
    logic          r5_cbpz;
    sct_pkg::t_wide r6_m1, r6_m2, r6_m3, r6_m4;
    logic          r6_cbpz;
    sct_pkg::t_wide r7_y, r7_x;
    logic          r7_cbpz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_p1  <= 32'(sct_pkg::qmul(34'(w_sbp), 34'(w_sb1)));
            r1_p2  <= 32'(sct_pkg::qmul(34'(w_cbp), 34'(w_cb1)));
            r1_t1  <= 32'(sct_pkg::qmul(34'(w_sd1), 34'(w_cb1)));
            r1_t2  <= 32'(sct_pkg::qmul(34'(w_sd0), 34'(w_cb0)));
            r1_sbp <= w_sbp;
            r1_cbp <= w_cbp;
            r1_sb1 <= w_sb1;
            r1_cd1 <= w_cd1;
            r1_sb0 <= w_sb0;

            r2_q    <= 32'(sct_pkg::qmul(34'(r1_p2), 34'(r1_cd1)));
            r2_s    <= 32'(sct_pkg::qmul(34'(r1_t1), 34'(r1_cbp)));
            r2_bb   <= 32'(sct_pkg::qmul(34'(r1_t2), 34'(r1_cbp)));
            r2_p1   <= r1_p1;
            r2_sbp  <= r1_sbp;
            r2_sb1  <= r1_sb1;
            r2_sb0  <= r1_sb0;
            r2_cbpz <= (r1_cbp == 0);

            r3_sb2  <= sct_pkg::clamp_q(64'(r2_p1) + 64'(r2_q));
            r3_s    <= r2_s;
            r3_bb   <= r2_bb;
            r3_sbp  <= r2_sbp;
            r3_sb1  <= r2_sb1;
            r3_sb0  <= r2_sb0;
            r3_cbpz <= r2_cbpz;

            r4_sq   <= 64'(r3_sb2) * 64'(r3_sb2);
            r4_qs   <= 32'(sct_pkg::qmul(34'(r3_sb2), 34'(r3_sbp)));
            r4_sb2  <= r3_sb2;
            r4_s    <= r3_s;
            r4_bb   <= r3_bb;
            r4_sb1  <= r3_sb1;
            r4_sb0  <= r3_sb0;
            r4_cbpz <= r3_cbpz;

            r5_n    <= 61'((64'sd1 <<< 60) - r4_sq);
            r5_c    <= 34'(r4_sb1) - 34'(r4_qs);
            r5_sb2  <= r4_sb2;
            r5_s    <= r4_s;
            r5_bb   <= r4_bb;
            r5_sb0  <= r4_sb0;
            r5_cbpz <= r4_cbpz;

            r6_m1   <= 34'(sct_pkg::qmul(34'(r5_s), 34'(r5_sb0)));
            r6_m2   <= 34'(sct_pkg::qmul(r5_c, 34'(r5_bb)));
            r6_m3   <= 34'(sct_pkg::qmul(r5_c, 34'(r5_sb0)));
            r6_m4   <= 34'(sct_pkg::qmul(34'(r5_s), 34'(r5_bb)));
            r6_cbpz <= r5_cbpz;

            r7_y    <= r6_m1 - r6_m2;
            r7_x    <= r6_m3 + r6_m4;
            r7_cbpz <= r6_cbpz;
        end
    end

    // latitude path
    logic [30:0]    w_cb2;
    sct_pkg::t_q30  w_sb2_d;
    sct_pkg::t_wide w_lat_x;

    sct_isqrt u_isqrt (.i_clk(i_clk), .i_en(w_en), .i_n(r5_n), .o_root(w_cb2));

    sct_delay #(.W(32), .D(LQ)) u_dly_sb2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_d(r5_sb2), .o_q(w_sb2_d));

    assign w_lat_x = {3'b000, w_cb2};

    // longitude path waits for the root
    sct_pkg::t_wide w_y_d, w_x_d;
    logic           w_cbpz_d;

    sct_delay #(.W(69), .D(LON_DLY)) u_dly_lon (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_d({r7_y, r7_x, r7_cbpz}), .o_q({w_y_d, w_x_d, w_cbpz_d}));

    logic signed [A-1:0] w_zlat, w_zlon;
    logic                w_flag_d;
    logic                w_valid_d;

    sct_atan2 #(.ANGLE_BITS(A), .CORDIC_STAGES(N)) u_at_lat (
        .i_clk(i_clk), .i_en(w_en), .i_y(34'(w_sb2_d)), .i_x(w_lat_x), .o_z(w_zlat));
    sct_atan2 #(.ANGLE_BITS(A), .CORDIC_STAGES(N)) u_at_lon (
        .i_clk(i_clk), .i_en(w_en), .i_y(w_y_d), .i_x(w_x_d), .o_z(w_zlon));

    sct_delay #(.W(1), .D(LA)) u_dly_flag (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_d((w_cb2 == 0) || w_cbpz_d), .o_q(w_flag_d));

    sct_delay #(.W(1), .D(LAT)) u_dly_valid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_d(i_in.valid), .o_q(w_valid_d));

    // output word
    logic signed [31:0] r_lon;
    sct_pkg::t_q30      r_lat;
    logic               r_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_valid_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lon  <= w_flag_d ? '0 : 32'(to_out32(w_zlon));
            r_lat  <= sct_pkg::clamp_q(to_out32(w_zlat));
            r_flag <= w_flag_d;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.lon_out    = r_lon;
    assign o_out.lat_out    = r_lat;
    assign o_out.degenerate = r_flag;

endmodule

FILE: test/sct_checker.sv
// checker for the rotation block: predicts each result word and compares
`timescale 1ns / 1ps

module sct_checker #(
    parameter int ANGLE_BITS    = 32,
    parameter int CORDIC_STAGES = 30
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_lon_in,
    input  logic [31:0] i_lat_in,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_lon_out,
    input  logic [31:0] i_lat_out,
    input  logic        i_degenerate,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [31:0] lon;
        logic [31:0] lat;
        logic        degen;
    } t_rot_word;

    t_rot_word expected_words[$];
    longint atan_tab[64];
    longint frame_origin_lon, frame_origin_lat, frame_pole_lon, frame_pole_lat;

    initial begin
        o_errors = 0;
        atan_tab[0] = longint'(1) << (ANGLE_BITS - 3);
        for (int i = 1; i < 64; i++) atan_tab[i] = sct_pkg::atan_entry(ANGLE_BITS, i);
    end

    function automatic longint asr(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint wrap_turn(longint v);
        longint u;
        u = v & ((longint'(1) << ANGLE_BITS) - 1);
        if (u[ANGLE_BITS-1]) return u - (longint'(1) << ANGLE_BITS);
        return u;
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint mul_q(longint a, longint b);
        return asr(a * b + (longint'(1) << (sct_pkg::QF - 1)), sct_pkg::QF);
    endfunction

    function automatic longint angle_in(logic [31:0] w);
        longint v;
        v = longint'(signed'(w));
        if (ANGLE_BITS >= 32) return v * (longint'(1) << (ANGLE_BITS - 32));
        return asr(v, 32 - ANGLE_BITS);
    endfunction

    function automatic longint angle_out(longint z);
        if (ANGLE_BITS > 32)
            return asr(z + (longint'(1) << (ANGLE_BITS - 33)), ANGLE_BITS - 32);
        return z * (longint'(1) << (32 - ANGLE_BITS));
    endfunction

    task automatic sin_cos(input longint th, output longint s, output longint c);
        longint x, y, z, dx, dy, qt, hf;
        bit flip;
        qt = longint'(1) << (ANGLE_BITS - 2);
        hf = longint'(1) << (ANGLE_BITS - 1);
        x = sct_pkg::KINV_Q;
        y = 0;
        flip = 0;
        th = wrap_turn(th);
        if (th > qt) begin
            th -= hf;
            flip = 1;
        end else if (th < -qt) begin
            th += hf;
            flip = 1;
        end
        z = th;
        for (int i = 0; i < CORDIC_STAGES && i < 64; i++) begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = clip(x, longint'(1) << sct_pkg::QF);
        s = clip(y, longint'(1) << sct_pkg::QF);
    endtask

    function automatic longint vector_angle(longint y, longint x);
        longint z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = longint'(1) << (ANGLE_BITS - 2);
            end else begin
                t = x; x = -y; y = t; z = -(longint'(1) << (ANGLE_BITS - 2));
            end
        end
        for (int i = 0; i < CORDIC_STAGES && i < 64; i++) begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_tab[i];
            end else begin
                x -= dx; y += dy; z -= atan_tab[i];
            end
        end
        return wrap_turn(z);
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b; r = (r >> 1) + b;
            end else r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    task automatic rotate_point(input logic [31:0] lon_w, input logic [31:0] lat_w,
                                output t_rot_word res);
        longint a0, b0, ap, bp, a1, b1;
        longint sb0, cb0, sbp, cbp, sb1, cb1, sd1, cd1, sd0, cd0;
        longint sb2, cb2, lat, lon, s, c, bb, y, x;
        a0 = angle_in(frame_origin_lon[31:0]);
        b0 = angle_in(frame_origin_lat[31:0]);
        ap = angle_in(frame_pole_lon[31:0]);
        bp = angle_in(frame_pole_lat[31:0]);
        a1 = angle_in(lon_w);
        b1 = angle_in(lat_w);
        sin_cos(b0, sb0, cb0);
        sin_cos(bp, sbp, cbp);
        sin_cos(b1, sb1, cb1);
        sin_cos(wrap_turn(ap - a1), sd1, cd1);
        sin_cos(wrap_turn(ap - a0), sd0, cd0);
        sb2 = clip(mul_q(sbp, sb1) + mul_q(mul_q(cbp, cb1), cd1),
                   longint'(1) << sct_pkg::QF);
        cb2 = int_sqrt((64'd1 << 60) - longint'(sb2 * sb2));
        lat = clip(angle_out(vector_angle(sb2, cb2)), longint'(1) << 30);
        lon = 0;
        res.degen = 0;
        if (cb2 == 0 || cbp == 0) begin
            res.degen = 1;
        end else begin
            s = mul_q(mul_q(sd1, cb1), cbp);
            c = sb1 - mul_q(sb2, sbp);
            bb = mul_q(mul_q(sd0, cb0), cbp);
            y = mul_q(s, sb0) - mul_q(c, bb);
            x = mul_q(c, sb0) + mul_q(s, bb);
            lon = angle_out(vector_angle(y, x));
        end
        res.lon = lon[31:0];
        res.lat = lat[31:0];
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        o_errors++;
    endtask

    assign o_pending = expected_words.size();

    always @(posedge i_clk) begin
        t_rot_word w, e;
        if (!i_rst_n) begin
            frame_origin_lon <= 64'sd1073741824;
            frame_origin_lat <= 0;
            frame_pole_lon <= 0;
            frame_pole_lat <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite) begin
                case (sct_pkg::t_reg_idx'(i_paddr[3:2]))
                    sct_pkg::REG_ORIGIN_LON: frame_origin_lon <= longint'(signed'(i_pwdata));
                    sct_pkg::REG_ORIGIN_LAT: frame_origin_lat <= longint'(signed'(i_pwdata));
                    sct_pkg::REG_POLE_LON:   frame_pole_lon <= longint'(signed'(i_pwdata));
                    sct_pkg::REG_POLE_LAT:   frame_pole_lat <= longint'(signed'(i_pwdata));
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                rotate_point(i_lon_in, i_lat_in, w);
                expected_words.push_back(w);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    report("unexpected word", i_lon_out, 0);
                end else begin
                    e = expected_words.pop_front();
                    if (i_lon_out !== e.lon) report("lon_out", i_lon_out, e.lon);
                    if (i_lat_out !== e.lat) report("lat_out", i_lat_out, e.lat);
                    if (i_degenerate !== e.degen)
                        report("degenerate", 32'(i_degenerate), 32'(e.degen));
                end
            end
        end
    end
endmodule

FILE: test/tb_spherical_coordinate_rotation.sv
// testbench top: stimulus, configuration phases, stalls and verdict
`timescale 1ns / 1ps

module tb_spherical_coordinate_rotation;

    localparam int LATENCY = 2 * 30 + 42;
    localparam int N_RANDOM = 1000;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [3:0] paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic pready;
    int errors, pending;
    int cycles = 0;
    bit quiet = 0;
    bit hold_sink = 0;

    sct_in_if in_ch();
    sct_out_if out_ch();

    initial begin
        in_ch.valid = 0;
        in_ch.lon_in = 0;
        in_ch.lat_in = 0;
        out_ch.ready = 0;
    end

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    spherical_coordinate_rotation uut (
        .i_clk, .i_rst_n, .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    sct_checker chk (
        .i_clk, .i_rst_n,
        .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready),
        .i_lon_in(in_ch.lon_in), .i_lat_in(in_ch.lat_in),
        .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_lon_out(out_ch.lon_out), .i_lat_out(out_ch.lat_out),
        .i_degenerate(out_ch.degenerate),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stall bursts, or a long hold when asked
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_sink) begin
                out_ch.ready <= 0;
                @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 9);
                out_ch.ready <= 0;
                repeat (n) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1;
                @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(input sct_pkg::t_reg_idx idx, input logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk iff pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge i_clk);
    endtask

    task automatic send_point(input logic [31:0] lon, input logic [31:0] lat,
                              input bit gaps);
        if (gaps && !quiet && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.lon_in <= lon;
        in_ch.lat_in <= lat;
        @(posedge i_clk iff in_ch.ready);
    endtask

    task automatic drain_all();
        in_ch.valid <= 0;
        @(posedge i_clk iff pending == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_lat();
        case ($urandom_range(0, 5))
            0: return 32'h4000_0000;
            1: return 32'hC000_0000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
        endcase
    endfunction

    logic [31:0] dir_lon[10] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000,
                                 32'hC000_0000, 32'hFFFF_FFFF, 32'h1, 32'h2000_0000,
                                 32'h0, 32'hAAAA_5555};
    logic [31:0] dir_lat[10] = '{32'h0, 32'h4000_0000, 32'hC000_0000, 32'h0,
                                 32'h4000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1,
                                 32'hFFFF_FFFF, 32'h5555_AAAA};

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset frame, extremes and the pole points
        foreach (dir_lon[i]) send_point(dir_lon[i], dir_lat[i], 0);
        drain_all();

        // pole with zero cosine, extreme origin
        write_reg(sct_pkg::REG_POLE_LAT, 32'h4000_0000);
        write_reg(sct_pkg::REG_ORIGIN_LON, 32'h8000_0000);
        write_reg(sct_pkg::REG_ORIGIN_LAT, 32'hC000_0000);
        write_reg(sct_pkg::REG_POLE_LON, 32'h7FFF_FFFF);
        foreach (dir_lon[i]) send_point(dir_lon[i], dir_lat[i], 0);
        drain_all();
        write_reg(sct_pkg::REG_POLE_LAT, 32'hC000_0000);
        write_reg(sct_pkg::REG_ORIGIN_LAT, 32'h4000_0000);
        send_point(0, 32'hC000_0000, 0);
        send_point(32'h7FFF_FFFF, 0, 0);
        drain_all();

        for (int ph = 0; ph < 5; ph++) begin
            write_reg(sct_pkg::REG_ORIGIN_LON, $urandom);
            write_reg(sct_pkg::REG_ORIGIN_LAT, rand_lat());
            write_reg(sct_pkg::REG_POLE_LON, $urandom);
            write_reg(sct_pkg::REG_POLE_LAT, ph == 4 ? 32'h2000_0000 : rand_lat());
            if (ph == 1) begin
                hold_sink = 1;
                fork
                    begin
                        repeat (LATENCY * 3) @(posedge i_clk);
                        hold_sink = 0;
                    end
                    for (int k = 0; k < LATENCY * 2; k++)
                        send_point($urandom, rand_lat(), 0);
                join
            end
            if (ph == 4) quiet = 1;
            for (int k = 0; k < N_RANDOM / 5; k++) begin
                if (!quiet && $urandom_range(0, 30) == 0) begin
                    in_ch.valid <= 0;
                    @(posedge i_clk iff pending == 0);
                end
                send_point($urandom, $urandom_range(0, 3) == 0 ? $urandom : rand_lat(), 1);
            end
            drain_all();
        end

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

FILE: files.f
design/sct_pkg.sv
design/sct_ifs.sv
design/sct_delay.sv
design/sct_sincos.sv
design/sct_atan2.sv
design/sct_isqrt.sv
design/spherical_coordinate_rotation.sv
test/sct_checker.sv
test/tb_spherical_coordinate_rotation.sv
